[rtl/bro_pkg.sv]
package bro_pkg;

  // request codes on func
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [6:0] THRESHOLD_RESET = 7'd20;
  localparam logic [6:0] RATE_FULL       = 7'd100;

  // controller to datapath
  typedef struct packed {
    logic clear;     // empty the box store
    logic load;      // append a box
    logic query;     // capture region, reset scan
    logic decide;    // evaluate current box
    logic div_step;  // one quotient bit
    logic advance;   // next box
    logic finish;    // present result
  } bro_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last_box;
    logic win;
    logic full_rate;
    logic div_last;
  } bro_stat_t;

endpackage

[rtl/box_region_overlap_matcher_top.sv]
// box region overlap matcher
// command channel: a request is taken on a rising edge with start high and
// busy low. func selects clear store, load box or query region; func 3 is
// dropped. clear and load complete in the accept cycle and busy stays low.
// a query raises busy and scans the stored boxes in load order, one box
// at a time through the fetch / geometry / multiply / scale / compare
// chain, plus a divider run each time a box takes the lead with a rate
// under 100; an empty store goes straight to the result. the memory read
// port and the divider are shared by every box, so one query is in
// flight at a time.
// result channel: done pulses one cycle with found, class, edges and
// rate; the receiver cannot hold it off. a new request may be issued in
// the done cycle.
// config channel: cfg_data writes the threshold register, always ready; write it
// only while idle.
// reset (synchronous, active high) empties the store and sets the
// threshold to 20; box contents are not cleared.
module box_region_overlap_matcher_top #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // command request
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [COORD_BITS-1:0] left_edge,
  input  logic [COORD_BITS-1:0] right_edge,
  input  logic [COORD_BITS-1:0] top_edge,
  input  logic [COORD_BITS-1:0] bottom_edge,
  input  logic [7:0]            class_label,
  // result
  output logic                  done,
  output logic                  found,
  output logic [7:0]            match_class,
  output logic [COORD_BITS-1:0] match_left,
  output logic [COORD_BITS-1:0] match_right,
  output logic [COORD_BITS-1:0] match_top,
  output logic [COORD_BITS-1:0] match_bottom,
  output logic [6:0]            best_rate,
  // threshold write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [6:0]            cfg_data
);
  import bro_pkg::*;

  bro_cmd_t  cmd;
  bro_stat_t stat;

  // threshold register is always writable
  assign cfg_ready = 1'b1;

  bro_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bro_dp #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .left_edge    (left_edge),
    .right_edge   (right_edge),
    .top_edge     (top_edge),
    .bottom_edge  (bottom_edge),
    .class_label  (class_label),
    .done         (done),
    .found        (found),
    .match_class  (match_class),
    .match_left   (match_left),
    .match_right  (match_right),
    .match_top    (match_top),
    .match_bottom (match_bottom),
    .best_rate    (best_rate)
  );

`ifndef SYNTHESIS
  // a result only follows a busy query
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without query");
  // busy is already low while the result is presented
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy still high at result");
  // rate stays a percentage
  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (best_rate <= RATE_FULL)) else $error("rate above 100");
  // no match reports zero fields
  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (best_rate == 7'd0 && match_class == 8'd0))
    else $error("nonzero fields without match");
  // a match exceeds the threshold, so its rate is above zero
  a_match_rate: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (best_rate != 7'd0)) else $error("match with zero rate");
`endif

endmodule

[rtl/bro_ctrl.sv]
module bro_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  bro_pkg::bro_stat_t stat,
  output bro_pkg::bro_cmd_t  cmd,
  output logic              busy
);
  import bro_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_GEOM, S_MUL, S_SCALE, S_TH, S_DEC, S_DIV, S_DONE
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.clear = (func == FUNC_CLEAR);
          cmd.load  = (func == FUNC_LOAD);
          cmd.query = (func == FUNC_QUERY);
          if (func == FUNC_QUERY) begin
            state_next = stat.empty ? S_DONE : S_READ;
          end
        end
      end
      S_READ:  state_next = S_GEOM;
      S_GEOM:  state_next = S_MUL;
      S_MUL:   state_next = S_SCALE;
      S_SCALE: state_next = S_TH;
      S_TH:    state_next = S_DEC;
      S_DEC: begin
        cmd.decide = 1'b1;
        if (stat.win && !stat.full_rate) begin
          state_next = S_DIV;
        end else begin
          cmd.advance = 1'b1;
          state_next  = stat.last_box ? S_DONE : S_READ;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          cmd.advance = 1'b1;
          state_next  = stat.last_box ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/bro_dp.sv]
module bro_dp #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bro_pkg::bro_cmd_t      cmd,
  output bro_pkg::bro_stat_t     stat,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_data,
  input  logic [COORD_BITS-1:0] left_edge,
  input  logic [COORD_BITS-1:0] right_edge,
  input  logic [COORD_BITS-1:0] top_edge,
  input  logic [COORD_BITS-1:0] bottom_edge,
  input  logic [7:0]            class_label,
  output logic                  done,
  output logic                  found,
  output logic [7:0]            match_class,
  output logic [COORD_BITS-1:0] match_left,
  output logic [COORD_BITS-1:0] match_right,
  output logic [COORD_BITS-1:0] match_top,
  output logic [COORD_BITS-1:0] match_bottom,
  output logic [6:0]            best_rate
);
  import bro_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int SW = C + 1;
  localparam int AW = 2 * SW;
  localparam int DW = AW - 1;
  localparam int NW = 2 * C + 9;
  localparam int EW = 4 * C + 8;
  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  // box store and fill count
  logic [EW-1:0] mem [MAX_BOXES];
  logic [EW-1:0] rd;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [6:0]    threshold;

  // region
  logic [C-1:0] ql, qr, qt, qb;

  always_ff @(posedge clk) begin
    if (cmd.load && (count != CW'(MAX_BOXES))) begin
      mem[count[IW-1:0]] <= {class_label, bottom_edge, top_edge, right_edge, left_edge};
    end
    rd <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      threshold <= THRESHOLD_RESET;
    end else begin
      if (cfg_we) threshold <= cfg_data;
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.load && (count != CW'(MAX_BOXES))) begin
        count <= count + CW'(1);
      end
    end
  end

  // geometry stage
  logic signed [SW-1:0] bl, br, bt, bb, rl, rr, rt, rb;
  logic signed [SW-1:0] wa, ha, wb, hb, ovw, ovh;
  logic signed [SW:0]   span_x, span_y, sum_w, sum_h;
  logic signed [SW-1:0] g_wa, g_ha, g_wb, g_hb, g_ovw, g_ovh;
  logic                 g_meet;

  always_comb begin
    bl = $signed({1'b0, rd[C-1:0]});
    br = $signed({1'b0, rd[2*C-1:C]});
    bt = $signed({1'b0, rd[3*C-1:2*C]});
    bb = $signed({1'b0, rd[4*C-1:3*C]});
    rl = $signed({1'b0, ql});
    rr = $signed({1'b0, qr});
    rt = $signed({1'b0, qt});
    rb = $signed({1'b0, qb});
    wa = br - bl;
    ha = bb - bt;
    wb = rr - rl;
    hb = rb - rt;
    span_x = (SW+1)'((br > rr) ? br : rr) - (SW+1)'((bl < rl) ? bl : rl);
    span_y = (SW+1)'((bb > rb) ? bb : rb) - (SW+1)'((bt < rt) ? bt : rt);
    sum_w  = (SW+1)'(wa) + (SW+1)'(wb);
    sum_h  = (SW+1)'(ha) + (SW+1)'(hb);
    ovw = ((br < rr) ? br : rr) - ((bl > rl) ? bl : rl);
    ovh = ((bb < rb) ? bb : rb) - ((bt > rt) ? bt : rt);
  end

  // product, scale and threshold stages
  logic signed [AW-1:0] m_aa, m_ab, m_ov;
  logic                 m_meet;
  logic [DW-1:0]        s_d;
  logic [NW-1:0]        s_n;
  logic                 s_degen, s_ovpos, s_meet;
  logic [NW-1:0]        t_prod, t_prod100;
  logic [6:0]           best, m_lim;
  logic [7:0]           m_inc;

  assign m_lim = (threshold > best) ? threshold : best;
  assign m_inc = {1'b0, m_lim} + 8'd1;

  always_ff @(posedge clk) begin
    g_wa   <= wa;
    g_ha   <= ha;
    g_wb   <= wb;
    g_hb   <= hb;
    g_ovw  <= ovw;
    g_ovh  <= ovh;
    g_meet <= (span_x <= sum_w) && (span_y <= sum_h);

    m_aa   <= AW'(g_wa) * AW'(g_ha);
    m_ab   <= AW'(g_wb) * AW'(g_hb);
    m_ov   <= AW'(g_ovw) * AW'(g_ovh);
    m_meet <= g_meet;

    s_degen <= (m_aa <= 0) || (m_ab <= 0);
    s_ovpos <= (m_ov > 0);
    s_meet  <= m_meet;
    s_d     <= (m_aa < m_ab) ? m_aa[DW-1:0] : m_ab[DW-1:0];
    s_n     <= NW'(m_ov[DW-1:0]) * NW'(RATE_FULL);

    t_prod    <= NW'(m_inc) * NW'(s_d);
    t_prod100 <= NW'(RATE_FULL) * NW'(s_d);
  end

  // win decision: rate > max(threshold, best) without dividing
  logic win, full_rate;
  assign full_rate = s_degen || (s_n >= t_prod100);
  assign win = s_meet && (m_lim < RATE_FULL) &&
               (s_degen || (s_ovpos && (s_n >= t_prod)));

  // restoring divider for the winner's rate, below 100 so 7 quotient bits
  logic [NW-1:0] rem, dsh;
  logic [6:0]    quo, quo_next;
  logic [2:0]    k;
  logic          ge;

  assign dsh      = NW'(s_d) << k;
  assign ge       = (rem >= dsh);
  assign quo_next = quo | (ge ? (7'd1 << k) : 7'd0);

  logic [EW-1:0] win_box;

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      ql    <= left_edge;
      qr    <= right_edge;
      qt    <= top_edge;
      qb    <= bottom_edge;
      idx   <= '0;
      best  <= '0;
      found <= 1'b0;
    end
    if (cmd.advance) idx <= idx + IW'(1);
    if (cmd.decide && win) begin
      found   <= 1'b1;
      win_box <= rd;
      if (full_rate) begin
        best <= RATE_FULL;
      end else begin
        rem <= s_n;
        quo <= '0;
        k   <= 3'd6;
      end
    end
    if (cmd.div_step) begin
      if (ge) rem <= rem - dsh;
      quo <= quo_next;
      k   <= k - 3'd1;
      if (k == 3'd0) best <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      match_class  <= found ? win_box[4*C+7:4*C] : 8'd0;
      match_bottom <= found ? win_box[4*C-1:3*C] : '0;
      match_top    <= found ? win_box[3*C-1:2*C] : '0;
      match_right  <= found ? win_box[2*C-1:C]   : '0;
      match_left   <= found ? win_box[C-1:0]     : '0;
      best_rate    <= found ? best : 7'd0;
    end
  end

  always_comb begin
    stat.empty     = (count == '0);
    stat.last_box  = ((CW'(idx) + CW'(1)) == count);
    stat.win       = win;
    stat.full_rate = full_rate;
    stat.div_last  = (k == 3'd0);
  end

endmodule
